/* rtl/mlcfp_pkg.sv */
// Shared types, constants and the CRC-16/CCITT byte update for the frame parser.
// Imported by mlcfp_ctrl, mlcfp_dp and the top level; no dependencies.
`default_nettype none

package mlcfp_pkg;

    localparam logic [7:0]  MagicB0 = 8'hAA;
    localparam logic [7:0]  MagicB1 = 8'h55;
    localparam logic [7:0]  MagicB2 = 8'hC3;
    localparam logic [7:0]  MagicB3 = 8'h3C;
    localparam logic [1:0]  MagicLastPos = 2'd3;
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h1021;

    typedef struct packed {
        logic restart;
        logic hunt_byte;
        logic load_len_lo;
        logic load_len_hi;
        logic load_type;
        logic load_payload;
        logic load_crc_lo;
        logic idx_clr;
        logic idx_inc;
        logic rd_issue;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic magic_done;
        logic len_too_big;
        logic len_zero;
        logic payload_done;
        logic crc_ok;
        logic drain_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        case (pos)
            2'd0:    m = MagicB0;
            2'd1:    m = MagicB1;
            2'd2:    m = MagicB2;
            default: m = MagicB3;
        endcase
        return m;
    endfunction

    // MSB-first CRC-16/CCITT, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/mlcfp_ctrl.sv */
// Frame parser controller: phase state machine, command decode and input stall.
// Depends on mlcfp_pkg for the command and status structs.
`default_nettype none

module mlcfp_ctrl
    import mlcfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_HUNT,
        S_LEN_LO,
        S_LEN_HI,
        S_TYPE,
        S_PAYLOAD,
        S_CRC_LO,
        S_CRC_HI,
        S_DRAIN_RD,
        S_DRAIN_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign o_stall = (r_state == S_DRAIN_RD) || (r_state == S_DRAIN_WR);
    assign acc     = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT: begin
                if (acc) begin
                    o_cmd.hunt_byte = 1'b1;
                    if (i_sts.magic_done) n_state = S_LEN_LO;
                end
            end
            S_LEN_LO: begin
                if (acc) begin
                    o_cmd.load_len_lo = 1'b1;
                    n_state = S_LEN_HI;
                end
            end
            S_LEN_HI: begin
                if (acc) begin
                    if (i_sts.len_too_big) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.load_len_hi = 1'b1;
                        n_state = S_TYPE;
                    end
                end
            end
            S_TYPE: begin
                if (acc) begin
                    o_cmd.load_type = 1'b1;
                    n_state = i_sts.len_zero ? S_CRC_LO : S_PAYLOAD;
                end
            end
            S_PAYLOAD: begin
                if (acc) begin
                    o_cmd.load_payload = 1'b1;
                    if (i_sts.payload_done) n_state = S_CRC_LO;
                end
            end
            S_CRC_LO: begin
                if (acc) begin
                    o_cmd.load_crc_lo = 1'b1;
                    n_state = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                if (acc) begin
                    if (i_sts.crc_ok) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = S_DRAIN_RD;
                    end else begin
                        o_cmd.restart = 1'b1;
                        n_state = S_HUNT;
                    end
                end
            end
            S_DRAIN_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_DRAIN_WR;
            end
            S_DRAIN_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.drain_done) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_DRAIN_RD;
                    end
                end
            end
            default: begin
                o_cmd.restart = 1'b1;
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_drain_exit_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> (r_state == S_HUNT))
        else $error("drain ended outside hunt");
`endif

endmodule

`default_nettype wire

/* rtl/mlcfp_dp.sv */
// Frame parser datapath: header registers, running CRC, payload memory, result register.
// Depends on mlcfp_pkg; driven by mlcfp_ctrl through t_dp_cmd, reports t_dp_sts.
`default_nettype none

module mlcfp_dp
    import mlcfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_stall,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    output logic            o_valid,
    output logic [7:0]      o_frame_type,
    output logic [5:0]      o_frame_length,
    output logic            o_has_data,
    output logic [4:0]      o_byte_index,
    output logic [7:0]      o_data_byte,
    output logic            o_last
);

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [1:0]    r_pos;
    logic [1:0]    n_pos;
    logic [7:0]    r_len_lo;
    logic [LW-1:0] r_len;
    logic [7:0]    r_type;
    logic [5:0]    r_cnt;
    logic [5:0]    n_cnt;
    logic [15:0]   r_crc;
    logic [7:0]    r_crc_lo;
    logic [5:0]    r_idx;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [MAX_PAYLOAD];

    logic          r_out_valid;
    logic [7:0]    r_out_type;
    logic [5:0]    r_out_len;
    logic          r_out_has;
    logic [4:0]    r_out_idx;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          magic_hit;
    logic [15:0]   len_full;
    logic [6:0]    len7;
    logic          wr_en;

    assign magic_hit = (i_rx_byte == magic_byte(r_pos));
    assign n_pos     = magic_hit ? (r_pos + 2'd1) : ((i_rx_byte == MagicB0) ? 2'd1 : 2'd0);
    assign len_full  = {i_rx_byte, r_len_lo};
    assign len7      = 7'(r_len);
    assign n_cnt     = r_cnt + 6'd1;
    assign wr_en     = i_cmd.load_payload && ({1'b0, r_cnt} < 7'(MAX_PAYLOAD));

    assign o_sts.magic_done   = magic_hit && (r_pos == MagicLastPos);
    assign o_sts.len_too_big  = len_full > 16'(MAX_PAYLOAD);
    assign o_sts.len_zero     = (len7 == 7'd0);
    assign o_sts.payload_done = {1'b0, n_cnt} >= len7;
    assign o_sts.crc_ok       = ({i_rx_byte, r_crc_lo} == r_crc);
    assign o_sts.drain_done   = (len7 == 7'd0) || (({1'b0, r_idx} + 7'd1) == len7);
    assign o_sts.out_free     = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_pos    <= '0;
            r_len_lo <= '0;
            r_len    <= '0;
            r_type   <= '0;
            r_cnt    <= '0;
            r_crc    <= CrcInit;
            r_crc_lo <= '0;
        end else begin
            if (i_cmd.hunt_byte) r_pos <= n_pos;
            if (i_cmd.load_len_lo) r_len_lo <= i_rx_byte;
            if (i_cmd.load_len_hi) r_len <= LW'(len_full);
            if (i_cmd.load_type) begin
                r_type <= i_rx_byte;
                r_cnt  <= '0;
                r_crc  <= crc16_byte(CrcInit, i_rx_byte);
            end
            if (i_cmd.load_payload) begin
                r_cnt <= n_cnt;
                r_crc <= crc16_byte(r_crc, i_rx_byte);
            end
            if (i_cmd.load_crc_lo) r_crc_lo <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_type <= r_type;
            r_out_len  <= len7[5:0];
            r_out_has  <= !o_sts.len_zero;
            r_out_idx  <= r_idx[4:0];
            r_out_byte <= o_sts.len_zero ? 8'h00 : r_rd_data;
            r_out_last <= o_sts.drain_done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_type   = r_out_type;
    assign o_frame_length = r_out_len;
    assign o_has_data     = r_out_has;
    assign o_byte_index   = r_out_idx;
    assign o_data_byte    = r_out_byte;
    assign o_last         = r_out_last;

`ifndef SYNTHESIS
    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over an untaken item");
    a_read_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (o_sts.len_zero || ({1'b0, r_idx} < len7)))
        else $error("payload read beyond frame length");
    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_len_hi |=> (len7 <= 7'(MAX_PAYLOAD)))
        else $error("accepted length above maximum payload");
`endif

endmodule

`default_nettype wire

/* rtl/magic_length_crc_frame_parser_top.sv */
// Results: after a good CRC each payload byte is read from the payload memory, then loaded
// into the result register (one result for an empty frame). Throughput: one byte per cycle
// through header and payload; the input stalls after a good CRC, while the payload memory
// is read out and while results wait on i_stall.
// Reset: synchronous, active low; clears the phase machine and result valid, not the memory.
// Depends on mlcfp_pkg, mlcfp_ctrl and mlcfp_dp.
`default_nettype none

module magic_length_crc_frame_parser_top
    import mlcfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_frame_type,
    output logic [5:0]      o_frame_length,
    output logic            o_has_data,
    output logic [4:0]      o_byte_index,
    output logic [7:0]      o_data_byte,
    output logic            o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mlcfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mlcfp_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length),
        .o_has_data     (o_has_data),
        .o_byte_index   (o_byte_index),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
